[hw/rtl/d2pc_pkg.sv]
// shared constants, config register codes and the result item type
`default_nettype none

package d2pc_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 24;

	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 8;
	localparam int INV_W   = 24;
	localparam int MASK_W  = 8;
	localparam int POS_W   = 27;
	localparam int SXY_W   = 47;
	localparam int SZ_W    = 36;
	localparam int CNT_W   = 21;
	localparam int LFSR_W  = 16;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	localparam int CENTER_COL_RST = 320;
	localparam int CENTER_ROW_RST = 240;
	localparam logic [INV_W-1:0]  INV_FOCAL_RST = 24'd31957;
	localparam logic [MASK_W-1:0] MASK_RST      = 8'd0;

	// magnitude limits of the signed coordinate range
	localparam logic [POS_W:0] POS_LIM = (POS_W+1)'((1 << (POS_W - 1)) - 1);
	localparam logic [POS_W:0] NEG_LIM = (POS_W+1)'(1 << (POS_W - 1));
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [DEPTH_W-1:0] Z_MAX = '1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_COL  = 3'd0,
		CFG_CENTER_ROW  = 3'd1,
		CFG_INV_FOCAL_X = 3'd2,
		CFG_INV_FOCAL_Y = 3'd3,
		CFG_SUB_MASK    = 3'd4
	} cfg_idx_t;

	localparam logic KIND_POINT    = 1'b0;
	localparam logic KIND_CENTROID = 1'b1;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic               kind;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [DEPTH_W-1:0] pos_z;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               centroid_valid;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/d2pc_fifo.sv]
// small register queue used between front and back and on the result side
`default_nettype none

module d2pc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_wr, do_rd;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/d2pc_front.sv]
// front end: config registers, subsample lfsr and pixel classification
`default_nettype none

module d2pc_front #(
	parameter int COORD_BITS = d2pc_pkg::COORD_BITS_DEF,
	parameter int CMD_W      = 2 * COORD_BITS + 42
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [d2pc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [d2pc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                push,
	input  wire logic [d2pc_pkg::DEPTH_W-1:0]        depth,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]        red,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]        green,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]        blue,
	input  wire logic [COORD_BITS-1:0]               col,
	input  wire logic [COORD_BITS-1:0]               row,
	input  wire logic                                end_of_frame,
	input  wire logic                                cmd_full,
	output logic                                     cmd_push,
	output logic      [CMD_W-1:0]                    cmd_data,
	output logic      [COORD_BITS-1:0]               center_col,
	output logic      [COORD_BITS-1:0]               center_row,
	output logic      [d2pc_pkg::INV_W-1:0]          inv_focal_x,
	output logic      [d2pc_pkg::INV_W-1:0]          inv_focal_y
);

	logic [d2pc_pkg::MASK_W-1:0] mask_q;
	logic [d2pc_pkg::LFSR_W-1:0] lfsr_q, lfsr_next;
	logic                        accept, nonzero, keep;

	always_comb begin
		lfsr_next = {1'b0, lfsr_q[d2pc_pkg::LFSR_W-1:1]}
			^ (lfsr_q[0] ? d2pc_pkg::LFSR_TAPS : '0);
		accept   = push && !cmd_full;
		nonzero  = (depth != '0);
		keep     = nonzero && ((lfsr_next[d2pc_pkg::MASK_W-1:0] & mask_q) == '0);
		// zero depth without end of frame leaves nothing for the back end
		cmd_push = accept && (keep || end_of_frame);
		cmd_data = {depth, red, green, blue, col, row, keep, end_of_frame};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col  <= COORD_BITS'(d2pc_pkg::CENTER_COL_RST);
			center_row  <= COORD_BITS'(d2pc_pkg::CENTER_ROW_RST);
			inv_focal_x <= d2pc_pkg::INV_FOCAL_RST;
			inv_focal_y <= d2pc_pkg::INV_FOCAL_RST;
			mask_q      <= d2pc_pkg::MASK_RST;
			lfsr_q      <= d2pc_pkg::LFSR_SEED;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					d2pc_pkg::CFG_CENTER_COL:  center_col  <= cfg_data[COORD_BITS-1:0];
					d2pc_pkg::CFG_CENTER_ROW:  center_row  <= cfg_data[COORD_BITS-1:0];
					d2pc_pkg::CFG_INV_FOCAL_X: inv_focal_x <= cfg_data[d2pc_pkg::INV_W-1:0];
					d2pc_pkg::CFG_INV_FOCAL_Y: inv_focal_y <= cfg_data[d2pc_pkg::INV_W-1:0];
					d2pc_pkg::CFG_SUB_MASK:    mask_q      <= cfg_data[d2pc_pkg::MASK_W-1:0];
					default: ;
				endcase
			end
			if (accept && nonzero) begin
				lfsr_q <= lfsr_next;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/d2pc_div.sv]
// three-lane restoring divider, one quotient bit per cycle, shared divisor
`default_nettype none

module d2pc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [d2pc_pkg::SXY_W-1:0]    dividend_x,
	input  wire logic [d2pc_pkg::SXY_W-1:0]    dividend_y,
	input  wire logic [d2pc_pkg::SXY_W-1:0]    dividend_z,
	input  wire logic [d2pc_pkg::CNT_W-1:0]    divisor,
	output logic                               done,
	output logic      [d2pc_pkg::SXY_W-1:0]    quot_x,
	output logic      [d2pc_pkg::SXY_W-1:0]    quot_y,
	output logic      [d2pc_pkg::SXY_W-1:0]    quot_z
);

	localparam int NL     = 3;
	localparam int DW     = d2pc_pkg::SXY_W;
	localparam int RW     = d2pc_pkg::CNT_W;
	localparam int STEP_W = $clog2(DW);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DW - 1);

	logic [DW-1:0]     quo_q [NL];
	logic [RW-1:0]     rem_q [NL];
	logic [DW-1:0]     quo_d [NL];
	logic [RW-1:0]     rem_d [NL];
	logic [DW-1:0]     load  [NL];
	logic [RW:0]       trial [NL];
	logic [RW-1:0]     divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;

	assign load[0] = dividend_x;
	assign load[1] = dividend_y;
	assign load[2] = dividend_z;
	assign quot_x  = quo_q[0];
	assign quot_y  = quo_q[1];
	assign quot_z  = quo_q[2];
	assign done    = done_q;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			// dividend bits shift out the top while quotient bits enter the bottom
			trial[i] = {rem_q[i], quo_q[i][DW-1]};
			if (trial[i] >= {1'b0, divisor_q}) begin
				rem_d[i] = RW'(trial[i] - {1'b0, divisor_q});
				quo_d[i] = {quo_q[i][DW-2:0], 1'b1};
			end else begin
				rem_d[i] = trial[i][RW-1:0];
				quo_d[i] = {quo_q[i][DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			for (int i = 0; i < NL; i++) begin
				quo_q[i] <= load[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < NL; i++) begin
				quo_q[i] <= quo_d[i];
				rem_q[i] <= rem_d[i];
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/d2pc_back.sv]
// back end: pinhole projection, frame sums and centroid sequencing
`default_nettype none

module d2pc_back #(
	parameter int COORD_BITS = d2pc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = d2pc_pkg::FRAC_BITS_DEF,
	parameter int CMD_W      = 2 * COORD_BITS + 42
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [COORD_BITS-1:0]         center_col,
	input  wire logic [COORD_BITS-1:0]         center_row,
	input  wire logic [d2pc_pkg::INV_W-1:0]    inv_focal_x,
	input  wire logic [d2pc_pkg::INV_W-1:0]    inv_focal_y,
	input  wire logic                          cmd_empty,
	input  wire logic [CMD_W-1:0]              cmd_data,
	output logic                               cmd_pop,
	input  wire logic                          res_full,
	output logic                               res_push,
	output d2pc_pkg::res_t                     res_data
);

	localparam int POS_W   = d2pc_pkg::POS_W;
	localparam int SXY_W   = d2pc_pkg::SXY_W;
	localparam int SZ_W    = d2pc_pkg::SZ_W;
	localparam int DEPTH_W = d2pc_pkg::DEPTH_W;
	localparam int COLOR_W = d2pc_pkg::COLOR_W;
	localparam int PROD1_W = COORD_BITS + DEPTH_W;
	localparam int PROD2_W = PROD1_W + d2pc_pkg::INV_W;
	localparam int RND_W   = PROD2_W + 1;
	localparam int Q_W     = RND_W - FRAC_BITS;
	localparam int EXT_W   = (Q_W > POS_W + 1) ? Q_W : POS_W + 1;
	localparam logic [RND_W-1:0] FRAC_MASK = RND_W'((64'd1 << FRAC_BITS) - 64'd1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL1   = 8'b0000_0010,
		ST_MUL2   = 8'b0000_0100,
		ST_RND    = 8'b0000_1000,
		ST_PT     = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_CEN    = 8'b1000_0000
	} back_state_t;

	// floor of the signed product over 2^FRAC_BITS, clamped to the coordinate range
	function automatic logic [POS_W-1:0] proj_sat(input logic neg,
			input logic [PROD2_W-1:0] p);
		logic [RND_W-1:0] rnd;
		logic [EXT_W-1:0] q;
		logic [POS_W:0]   mag;
		rnd = {1'b0, p} + (neg ? FRAC_MASK : '0);
		q   = EXT_W'(rnd[RND_W-1:FRAC_BITS]);
		if (neg) begin
			mag = (q > EXT_W'(d2pc_pkg::NEG_LIM)) ? d2pc_pkg::NEG_LIM : q[POS_W:0];
		end else begin
			mag = (q > EXT_W'(d2pc_pkg::POS_LIM)) ? d2pc_pkg::POS_LIM : q[POS_W:0];
		end
		return neg ? POS_W'(-mag) : POS_W'(mag);
	endfunction

	function automatic logic [POS_W-1:0] cen_sat(input logic neg,
			input logic [SXY_W-1:0] q);
		logic [POS_W:0] mag;
		if (neg) begin
			mag = (q > SXY_W'(d2pc_pkg::NEG_LIM)) ? d2pc_pkg::NEG_LIM : q[POS_W:0];
		end else begin
			mag = (q > SXY_W'(d2pc_pkg::POS_LIM)) ? d2pc_pkg::POS_LIM : q[POS_W:0];
		end
		return neg ? POS_W'(-mag) : POS_W'(mag);
	endfunction

	back_state_t state_q, state_d;

	logic [DEPTH_W-1:0]    c_depth;
	logic [COLOR_W-1:0]    c_red, c_green, c_blue;
	logic [COORD_BITS-1:0] c_col, c_row;
	logic                  c_keep, c_eof;

	logic [DEPTH_W-1:0]    depth_q;
	logic [COLOR_W-1:0]    red_q, green_q, blue_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic                  eof_q;
	logic                  neg_x, neg_y, neg_x_q, neg_y_q;
	logic [COORD_BITS-1:0] mag_x, mag_y;
	logic [PROD1_W-1:0]    prod1_x_q, prod1_y_q;
	logic [PROD2_W-1:0]    prod2_x_q, prod2_y_q;
	logic [POS_W-1:0]      px_q, py_q;

	logic [SXY_W-1:0]      sum_x_q, sum_y_q;
	logic [SZ_W-1:0]       sum_z_q;
	logic [d2pc_pkg::CNT_W-1:0] cnt_q;
	logic                  sgn_x_q, sgn_y_q;

	logic                  div_start, div_done;
	logic [SXY_W-1:0]      abs_x, abs_y, quot_x, quot_y, quot_z;
	logic                  cnt_zero;

	assign {c_depth, c_red, c_green, c_blue, c_col, c_row, c_keep, c_eof} = cmd_data;
	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		neg_x = col_q < center_col;
		neg_y = row_q < center_row;
		mag_x = neg_x ? (center_col - col_q) : (col_q - center_col);
		mag_y = neg_y ? (center_row - row_q) : (row_q - center_row);
		abs_x = sum_x_q[SXY_W-1] ? (-sum_x_q) : sum_x_q;
		abs_y = sum_y_q[SXY_W-1] ? (-sum_y_q) : sum_y_q;
	end

	always_comb begin
		cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
		div_start = (state_q == ST_DSTART) && !cnt_zero;
		res_push  = 1'b0;
		res_data  = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					state_d = c_keep ? ST_MUL1 : ST_DSTART;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_RND;
			ST_RND:  state_d = ST_PT;
			ST_PT: begin
				res_push       = !res_full;
				res_data.kind  = d2pc_pkg::KIND_POINT;
				res_data.pos_x = px_q;
				res_data.pos_y = py_q;
				res_data.pos_z = depth_q;
				res_data.red   = red_q;
				res_data.green = green_q;
				res_data.blue  = blue_q;
				res_data.last  = !eof_q;
				if (!res_full) begin
					state_d = eof_q ? ST_DSTART : ST_IDLE;
				end
			end
			ST_DSTART: state_d = cnt_zero ? ST_CEN : ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CEN;
				end
			end
			ST_CEN: begin
				res_push                = !res_full;
				res_data.kind           = d2pc_pkg::KIND_CENTROID;
				res_data.centroid_valid = !cnt_zero;
				res_data.last           = 1'b1;
				if (!cnt_zero) begin
					res_data.pos_x = cen_sat(sgn_x_q, quot_x);
					res_data.pos_y = cen_sat(sgn_y_q, quot_y);
					res_data.pos_z = (quot_z > SXY_W'(d2pc_pkg::Z_MAX)) ?
						d2pc_pkg::Z_MAX : quot_z[DEPTH_W-1:0];
				end
				if (!res_full) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			// a full count stops the sums, the point itself still goes out
			if ((state_q == ST_PT) && res_push && (cnt_q != d2pc_pkg::CNT_MAX)) begin
				sum_x_q <= sum_x_q + SXY_W'($signed(px_q));
				sum_y_q <= sum_y_q + SXY_W'($signed(py_q));
				sum_z_q <= sum_z_q + SZ_W'(depth_q);
				cnt_q   <= cnt_q + 1'b1;
			end
			if ((state_q == ST_CEN) && res_push) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				cnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			depth_q <= c_depth;
			red_q   <= c_red;
			green_q <= c_green;
			blue_q  <= c_blue;
			col_q   <= c_col;
			row_q   <= c_row;
			eof_q   <= c_eof;
		end
		if (state_q == ST_MUL1) begin
			neg_x_q   <= neg_x;
			neg_y_q   <= neg_y;
			prod1_x_q <= PROD1_W'(mag_x) * PROD1_W'(depth_q);
			prod1_y_q <= PROD1_W'(mag_y) * PROD1_W'(depth_q);
		end
		if (state_q == ST_MUL2) begin
			prod2_x_q <= PROD2_W'(prod1_x_q) * PROD2_W'(inv_focal_x);
			prod2_y_q <= PROD2_W'(prod1_y_q) * PROD2_W'(inv_focal_y);
		end
		if (state_q == ST_RND) begin
			px_q <= proj_sat(neg_x_q, prod2_x_q);
			py_q <= proj_sat(neg_y_q, prod2_y_q);
		end
		if (div_start) begin
			sgn_x_q <= sum_x_q[SXY_W-1];
			sgn_y_q <= sum_y_q[SXY_W-1];
		end
	end

	d2pc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend_x (abs_x),
		.dividend_y (abs_y),
		.dividend_z (SXY_W'(sum_z_q)),
		.divisor    (cnt_q),
		.done       (div_done),
		.quot_x     (quot_x),
		.quot_y     (quot_y),
		.quot_z     (quot_z)
	);

endmodule

`default_nettype wire

[hw/rtl/depth_to_point_cloud_unit.sv]
// Back-projects depth pixels into colored 3-D points and closes each frame with a centroid.
//
// Pixels enter on a queue-style port: an item transfers when push is high and full is low.
// Results leave the same way: the oldest result sits on the ports while empty is low and
// transfers when pop is high. Zero-depth pixels are dropped at the front in the cycle they
// arrive, so they stream at one per clock while full is low. A kept pixel passes through
// the back end's two multiplier stages, a rounding stage and the output write, which waits
// while the result queue is full; the back end takes no new pixel until that write is done.
// An end-of-frame pixel adds a centroid result, which waits for a bit-serial division of
// the frame sums by the point count; an empty frame skips the division.
// A four-entry queue between front and back lets the front keep taking pixels while the
// back end works; full rises only when that queue fills.
// When the receiver stops popping, the four-entry result queue fills, the back end waits
// and the command queue then backs up to the input.
// Configuration writes use cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write
// only while no pixel is in flight. Reset clears both queues, the frame sums and count,
// loads the subsample lfsr with its seed and the registers with their defaults.
`default_nettype none

module depth_to_point_cloud_unit #(
	parameter int COORD_BITS = d2pc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = d2pc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [d2pc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [d2pc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic [d2pc_pkg::DEPTH_W-1:0]         depth,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]         red,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]         green,
	input  wire logic [d2pc_pkg::COLOR_W-1:0]         blue,
	input  wire logic [COORD_BITS-1:0]                col,
	input  wire logic [COORD_BITS-1:0]                row,
	input  wire logic                                 end_of_frame,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic                                      kind,
	output logic signed [d2pc_pkg::POS_W-1:0]         pos_x,
	output logic signed [d2pc_pkg::POS_W-1:0]         pos_y,
	output logic        [d2pc_pkg::DEPTH_W-1:0]       pos_z,
	output logic        [d2pc_pkg::COLOR_W-1:0]       out_red,
	output logic        [d2pc_pkg::COLOR_W-1:0]       out_green,
	output logic        [d2pc_pkg::COLOR_W-1:0]       out_blue,
	output logic                                      centroid_valid,
	output logic                                      last
);

	localparam int CMD_W = d2pc_pkg::DEPTH_W + 3 * d2pc_pkg::COLOR_W + 2 * COORD_BITS + 2;
	localparam int RES_W = $bits(d2pc_pkg::res_t);

	logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic [CMD_W-1:0]              cmd_wr_data, cmd_rd_data;
	logic [COORD_BITS-1:0]         center_col, center_row;
	logic [d2pc_pkg::INV_W-1:0]    inv_focal_x, inv_focal_y;
	logic                          res_push, res_full;
	d2pc_pkg::res_t                res_wr_data, res_out;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;

	d2pc_front #(
		.COORD_BITS (COORD_BITS),
		.CMD_W      (CMD_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.depth        (depth),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.col          (col),
		.row          (row),
		.end_of_frame (end_of_frame),
		.cmd_full     (cmd_full),
		.cmd_push     (cmd_push),
		.cmd_data     (cmd_wr_data),
		.center_col   (center_col),
		.center_row   (center_row),
		.inv_focal_x  (inv_focal_x),
		.inv_focal_y  (inv_focal_y)
	);

	d2pc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (d2pc_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr_data),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd_data),
		.empty   (cmd_empty)
	);

	d2pc_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.CMD_W      (CMD_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.center_col  (center_col),
		.center_row  (center_row),
		.inv_focal_x (inv_focal_x),
		.inv_focal_y (inv_focal_y),
		.cmd_empty   (cmd_empty),
		.cmd_data    (cmd_rd_data),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_data    (res_wr_data)
	);

	d2pc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (d2pc_pkg::RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign kind           = res_out.kind;
	assign pos_x          = $signed(res_out.pos_x);
	assign pos_y          = $signed(res_out.pos_y);
	assign pos_z          = res_out.pos_z;
	assign out_red        = res_out.red;
	assign out_green      = res_out.green;
	assign out_blue       = res_out.blue;
	assign centroid_valid = res_out.centroid_valid;
	assign last           = res_out.last;

endmodule

`default_nettype wire

[hw/rtl/d2pc_checker.sv]
// port-level checks on the result channel, bound to the top level
`default_nettype none

module d2pc_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 empty,
	input wire logic                                 pop,
	input wire logic                                 kind,
	input wire logic signed [d2pc_pkg::POS_W-1:0]    pos_x,
	input wire logic signed [d2pc_pkg::POS_W-1:0]    pos_y,
	input wire logic        [d2pc_pkg::DEPTH_W-1:0]  pos_z,
	input wire logic        [d2pc_pkg::COLOR_W-1:0]  out_red,
	input wire logic        [d2pc_pkg::COLOR_W-1:0]  out_green,
	input wire logic        [d2pc_pkg::COLOR_W-1:0]  out_blue,
	input wire logic                                 centroid_valid,
	input wire logic                                 last
);

	// nothing waits on the result side while reset is applied
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

	// a centroid always closes the results of its pixel
	a_centroid_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == d2pc_pkg::KIND_CENTROID) |-> last)
		else $error("centroid result without last");

	// a point carries no centroid flag
	a_point_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == d2pc_pkg::KIND_POINT) |-> !centroid_valid)
		else $error("point result with centroid flag");

	// centroid has no color, and an empty frame has a zero position
	a_centroid_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == d2pc_pkg::KIND_CENTROID) |->
		(out_red == '0 && out_green == '0 && out_blue == '0 &&
		(centroid_valid || (pos_x == '0 && pos_y == '0 && pos_z == '0))))
		else $error("centroid fields malformed");

	// a result that is not popped stays put (checked on pos_x, pos_z and kind)
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(pos_z) && $stable(kind)))
		else $error("waiting result changed");

endmodule

bind depth_to_point_cloud_unit d2pc_checker u_d2pc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.kind           (kind),
	.pos_x          (pos_x),
	.pos_y          (pos_y),
	.pos_z          (pos_z),
	.out_red        (out_red),
	.out_green      (out_green),
	.out_blue       (out_blue),
	.centroid_valid (centroid_valid),
	.last           (last)
);

`default_nettype wire
